// File: src/fsts_pkg.sv
`default_nettype none
package fsts_pkg;

  localparam logic [2:0] OP_SCHED  = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_BLOCK  = 3'd2;
  localparam logic [2:0] OP_WAKE   = 3'd3;
  localparam logic [2:0] OP_CHARGE = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;

  localparam logic [2:0] ST_ABSENT    = 3'd0;
  localparam logic [2:0] ST_READY     = 3'd1;
  localparam logic [2:0] ST_RUNNING   = 3'd2;
  localparam logic [2:0] ST_BLOCKED   = 3'd3;
  localparam logic [2:0] ST_SUSPENDED = 3'd4;
  localparam logic [2:0] ST_DEFUNCT   = 3'd5;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_MUTEX = 2'd1;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  localparam logic [1:0] EST_READY = 2'd1;
  localparam logic [1:0] EST_SUSP  = 2'd2;
  localparam logic [1:0] EST_BAD   = 2'd3;

  localparam logic [1:0] RK_MUTEX = 2'd0;
  localparam logic [1:0] RK_SCHED = 2'd1;
  localparam logic [1:0] RK_ACK   = 2'd2;

  localparam logic [1:0] CFG_LOAD_PERIOD = 2'd0;
  localparam logic [1:0] CFG_RUN_TICK    = 2'd1;
  localparam logic [1:0] CFG_FROZEN      = 2'd2;

  localparam logic [31:0] LOAD_PERIOD_RST = 32'd100000;
  localparam logic [31:0] RUN_TICK_RST    = 32'd10000;
  localparam logic [31:0] NO_TIMEOUT      = 32'hffffffff;
  localparam logic [31:0] AVOID_SCORE     = 32'hfffffffe;
  localparam logic [7:0]  LOAD_MAX        = 8'd255;
  localparam logic [3:0]  MAX_WAITERS     = 4'd15;

  localparam int DVD_W = 40;
  localparam int DSR_W = 32;

  typedef struct packed {
    logic [2:0]         op;
    logic [3:0]         slot;
    logic               hint_valid;
    logic [3:0]         avoid_slot;
    logic               avoid_valid;
    logic [31:0]        now;
    logic               stack_ok;
    logic [31:0]        amount;
    logic signed [31:0] timeout;
    logic [1:0]         block_kind;
    logic [1:0]         entry_state;
    logic               entry_user;
  } fsts_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [3:0]  thread_slot;
    logic        wakeup_valid;
    logic [31:0] wakeup_delay;
    logic        stack_overflow;
    logic [2:0]  state_out;
    logic [7:0]  load_out;
    logic        last;
  } fsts_out_t;

  typedef struct packed {
    logic [2:0]  st;
    logic [1:0]  kind;
    logic [31:0] tmo;
    logic [31:0] start;
    logic [31:0] cpu;
    logic [7:0]  prio;
    logic        user;
    logic [7:0]  load;
  } fsts_ent_t;

endpackage
`default_nettype wire

// File: src/fsts_ram.sv
`default_nettype none
module fsts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: src/fsts_div.sv
`default_nettype none
module fsts_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fsts_pkg::DVD_W-1:0] dividend,
  input  logic [fsts_pkg::DSR_W-1:0] divisor,
  output logic                       done,
  output logic [fsts_pkg::DVD_W-1:0] quotient
);

  localparam int DW = fsts_pkg::DVD_W;
  localparam int SW = fsts_pkg::DSR_W;
  localparam int CW = $clog2(DW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] dvd_r;
  logic [SW-1:0] rem_r;
  logic [SW-1:0] dsr_r;
  logic [SW:0]   sh;
  logic [SW:0]   sub;
  logic          ge;

  assign sh  = {rem_r, dvd_r[DW-1]};
  assign sub = sh - {1'b0, dsr_r};
  assign ge  = sh >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW - 1);
        dvd_r  <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? sub[SW-1:0] : sh[SW-1:0];
        dvd_r <= {dvd_r[DW-2:0], ge};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule
`default_nettype wire

// File: src/fair_share_thread_scheduler.sv
`default_nettype none
// Thread table scheduler. Write, an ignored block and an unknown op go from idle straight
// to the acknowledge; block, wake, charge and read first pass the registered read of the
// thread table memory. A schedule walks every slot once; a slot may need the shared
// bit-serial divider for up to two divisions (one for the load when a load period has
// elapsed and the slot has cpu time, one for the score of a ready slot with nonzero
// priority other than the avoid slot when not frozen); a stalled result side holds it.
// After reset the table is cleared slot by slot, during which in_stall stays high. Results
// wait in one output register; the block holds its sequence until that register is free.
module fair_share_thread_scheduler #(
  parameter int NUM_THREADS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fsts_pkg::fsts_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fsts_pkg::fsts_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int IW = $clog2(NUM_THREADS);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_THREADS - 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_LD, S_LSTART, S_LWAIT, S_TMO, S_EMIT,
    S_SCORE, S_SWAIT, S_NEXT, S_PICK, S_FRD, S_FLD, S_DEC, S_ACK
  } state_t;

  state_t              state_r;
  fsts_pkg::fsts_in_t  in_r;
  logic [IW-1:0]       addr_r;
  logic [IW-1:0]       run_r;
  logic [IW-1:0]       chosen_r;
  logic [31:0]         llt_r;
  logic [31:0]         load_period_r;
  logic [31:0]         run_tick_r;
  logic                frozen_r;
  logic                ovf_r;
  logic                load_due_r;
  logic [31:0]         diff_r;
  fsts_pkg::fsts_ent_t ent_r;
  logic [3:0]          n_r;
  logic [31:0]         best_r;
  logic [31:0]         nu_r;
  logic                hint_rdy_r;
  logic [2:0]          rd_st_r;
  logic [7:0]          rd_load_r;
  logic                out_valid_r;
  fsts_pkg::fsts_out_t out_data_r;
  fsts_pkg::fsts_out_t out_data_nxt;
  logic                out_load;

  fsts_pkg::fsts_ent_t rd_ent;
  fsts_pkg::fsts_ent_t wr_ent;
  fsts_pkg::fsts_ent_t ent_s1;
  logic                ram_we;
  logic [IW-1:0]       ram_waddr;

  logic                       acc;
  logic                       in_ok;
  logic                       out_free;
  logic [31:0]                diff_c;
  logic [31:0]                left_c;
  logic                       tmo_live;
  logic                       score_go;
  logic                       avoid_hit;
  logic [IW-1:0]              pick_idx;
  logic                       dec_wv;
  logic [31:0]                dec_delay;
  logic                       div_start;
  logic [fsts_pkg::DVD_W-1:0] div_dvd;
  logic [fsts_pkg::DSR_W-1:0] div_dsr;
  logic                       div_done;
  logic [fsts_pkg::DVD_W-1:0] div_q;

  assign in_stall  = (state_r != S_IDLE);
  assign acc       = in_valid && !in_stall;
  assign in_ok     = int'(in_data.slot) < NUM_THREADS;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign diff_c    = in_data.now - llt_r;
  assign left_c    = ent_r.start + ent_r.tmo - in_r.now;
  assign tmo_live  = !frozen_r && ent_r.st == fsts_pkg::ST_BLOCKED
                     && ent_r.tmo != fsts_pkg::NO_TIMEOUT;
  assign score_go  = !frozen_r && ent_r.st == fsts_pkg::ST_READY && ent_r.prio != '0;
  assign avoid_hit = in_r.avoid_valid && int'(in_r.avoid_slot) == int'(addr_r);

  always_comb begin
    if (frozen_r) begin
      pick_idx = '0;
    end else if (in_r.hint_valid && int'(in_r.slot) < NUM_THREADS && hint_rdy_r) begin
      pick_idx = IW'(in_r.slot);
    end else begin
      pick_idx = chosen_r;
    end
  end

  always_comb begin
    dec_wv    = 1'b0;
    dec_delay = fsts_pkg::NO_TIMEOUT;
    if (!frozen_r) begin
      if (chosen_r != '0) begin
        dec_wv    = 1'b1;
        dec_delay = run_tick_r;
      end else if (nu_r != fsts_pkg::NO_TIMEOUT) begin
        dec_wv    = 1'b1;
        dec_delay = nu_r;
      end
    end
  end

  always_comb begin
    out_load     = 1'b0;
    out_data_nxt = '0;
    unique case (state_r)
      S_EMIT: begin
        out_load                 = out_free;
        out_data_nxt.result_kind = fsts_pkg::RK_MUTEX;
        out_data_nxt.thread_slot = 4'(addr_r);
      end
      S_DEC: begin
        out_load                    = out_free;
        out_data_nxt.result_kind    = fsts_pkg::RK_SCHED;
        out_data_nxt.thread_slot    = 4'(chosen_r);
        out_data_nxt.wakeup_valid   = dec_wv;
        out_data_nxt.wakeup_delay   = dec_delay;
        out_data_nxt.stack_overflow = ovf_r;
        out_data_nxt.last           = 1'b1;
      end
      S_ACK: begin
        out_load                 = out_free;
        out_data_nxt.result_kind = fsts_pkg::RK_ACK;
        out_data_nxt.thread_slot = in_r.slot;
        out_data_nxt.state_out   = rd_st_r;
        out_data_nxt.load_out    = rd_load_r;
        out_data_nxt.last        = 1'b1;
      end
      default: ;
    endcase
  end

  // running -> ready, then stack overflow handling, for the slot being walked
  always_comb begin
    ent_s1 = rd_ent;
    if (addr_r == run_r && ent_s1.st == fsts_pkg::ST_RUNNING) begin
      ent_s1.st = fsts_pkg::ST_READY;
    end
    if (ovf_r) begin
      if (ent_s1.user && ent_s1.st != fsts_pkg::ST_ABSENT) begin
        ent_s1.st = fsts_pkg::ST_SUSPENDED;
      end
      if (addr_r == run_r) begin
        ent_s1.st   = fsts_pkg::ST_DEFUNCT;
        ent_s1.kind = fsts_pkg::KIND_NONE;
      end
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = {8'd0, ent_r.cpu};
    div_dsr   = {24'd0, ent_r.prio};
    if (state_r == S_LSTART) begin
      div_start = ent_r.cpu != '0;
      div_dvd   = {ent_r.cpu, 8'd0} - {8'd0, ent_r.cpu};
      div_dsr   = diff_r;
    end else if (state_r == S_SCORE) begin
      div_start = score_go && !avoid_hit;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    wr_ent    = rd_ent;
    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        wr_ent    = '0;
        wr_ent.st = (addr_r == '0) ? fsts_pkg::ST_RUNNING : fsts_pkg::ST_ABSENT;
      end
      S_IDLE: begin
        ram_we = acc && in_data.op == fsts_pkg::OP_WRITE && in_ok
                 && in_data.slot != '0 && in_data.entry_state != fsts_pkg::EST_BAD;
        ram_waddr   = IW'(in_data.slot);
        wr_ent      = '0;
        wr_ent.st   = (in_data.entry_state == fsts_pkg::EST_READY) ? fsts_pkg::ST_READY :
                      (in_data.entry_state == fsts_pkg::EST_SUSP) ? fsts_pkg::ST_SUSPENDED :
                      fsts_pkg::ST_ABSENT;
        wr_ent.user = in_data.entry_user;
        wr_ent.prio = in_data.amount[7:0];
      end
      S_LD: begin
        case (in_r.op)
          fsts_pkg::OP_BLOCK: begin
            ram_we       = 1'b1;
            wr_ent.st    = fsts_pkg::ST_BLOCKED;
            wr_ent.kind  = in_r.block_kind;
            wr_ent.tmo   = in_r.timeout;
            wr_ent.start = in_r.now;
          end
          fsts_pkg::OP_WAKE: begin
            ram_we      = rd_ent.st == fsts_pkg::ST_BLOCKED;
            wr_ent.st   = fsts_pkg::ST_READY;
            wr_ent.kind = fsts_pkg::KIND_NONE;
            wr_ent.tmo  = '0;
          end
          fsts_pkg::OP_CHARGE: begin
            ram_we     = 1'b1;
            wr_ent.cpu = rd_ent.cpu + in_r.amount;
          end
          default: ;
        endcase
      end
      S_SCORE: begin
        ram_we = 1'b1;
        wr_ent = ent_r;
      end
      S_FLD: begin
        ram_we    = 1'b1;
        wr_ent.st = fsts_pkg::ST_RUNNING;
      end
      default: ;
    endcase
  end

  fsts_ram #(
    .WIDTH ($bits(fsts_pkg::fsts_ent_t)),
    .DEPTH (NUM_THREADS)
  ) u_tab (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_ent),
    .raddr (addr_r),
    .rdata (rd_ent)
  );

  fsts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR;
      addr_r        <= '0;
      run_r         <= '0;
      llt_r         <= '0;
      load_period_r <= fsts_pkg::LOAD_PERIOD_RST;
      run_tick_r    <= fsts_pkg::RUN_TICK_RST;
      frozen_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          fsts_pkg::CFG_LOAD_PERIOD: load_period_r <= cfg_data;
          fsts_pkg::CFG_RUN_TICK:    run_tick_r    <= cfg_data;
          fsts_pkg::CFG_FROZEN:      frozen_r      <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= out_data_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          if (addr_r == LAST_IDX) begin
            addr_r  <= '0;
            state_r <= S_IDLE;
          end else begin
            addr_r <= addr_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (acc) begin
            in_r      <= in_data;
            rd_st_r   <= '0;
            rd_load_r <= '0;
            unique case (in_data.op)
              fsts_pkg::OP_SCHED: begin
                ovf_r      <= run_r != '0 && !in_data.stack_ok;
                load_due_r <= diff_c > load_period_r;
                diff_r     <= diff_c;
                if (diff_c > load_period_r) begin
                  llt_r <= in_data.now;
                end
                addr_r     <= '0;
                n_r        <= '0;
                best_r     <= fsts_pkg::NO_TIMEOUT;
                nu_r       <= fsts_pkg::NO_TIMEOUT;
                chosen_r   <= '0;
                hint_rdy_r <= 1'b0;
                state_r    <= S_RD;
              end
              fsts_pkg::OP_BLOCK: begin
                addr_r  <= run_r;
                state_r <= (run_r != '0 && in_data.timeout != '0
                            && in_data.block_kind != fsts_pkg::KIND_BAD) ? S_RD : S_ACK;
              end
              fsts_pkg::OP_WAKE, fsts_pkg::OP_READ: begin
                addr_r  <= IW'(in_data.slot);
                state_r <= in_ok ? S_RD : S_ACK;
              end
              fsts_pkg::OP_CHARGE: begin
                addr_r  <= run_r;
                state_r <= S_RD;
              end
              default: state_r <= S_ACK;
            endcase
          end
        end
        S_RD: state_r <= S_LD;
        S_LD: begin
          if (in_r.op == fsts_pkg::OP_SCHED) begin
            ent_r   <= ent_s1;
            state_r <= load_due_r ? S_LSTART : S_TMO;
          end else begin
            if (in_r.op == fsts_pkg::OP_READ) begin
              rd_st_r   <= rd_ent.st;
              rd_load_r <= rd_ent.load;
            end
            state_r <= S_ACK;
          end
        end
        S_LSTART: begin
          if (ent_r.cpu == '0) begin
            ent_r.load <= '0;
            state_r    <= S_TMO;
          end else begin
            state_r <= S_LWAIT;
          end
        end
        S_LWAIT: begin
          if (div_done) begin
            ent_r.load <= (|div_q[fsts_pkg::DVD_W-1:8]) ? fsts_pkg::LOAD_MAX : div_q[7:0];
            ent_r.cpu  <= '0;
            state_r    <= S_TMO;
          end
        end
        S_TMO: begin
          if (tmo_live && left_c[31]) begin
            ent_r.st   <= fsts_pkg::ST_READY;
            ent_r.kind <= fsts_pkg::KIND_NONE;
            ent_r.tmo  <= '0;
            state_r    <= (ent_r.kind == fsts_pkg::KIND_MUTEX && n_r < fsts_pkg::MAX_WAITERS)
                          ? S_EMIT : S_SCORE;
          end else begin
            if (tmo_live && left_c < nu_r) begin
              nu_r <= left_c;
            end
            state_r <= S_SCORE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            n_r     <= n_r + 1'b1;
            state_r <= S_SCORE;
          end
        end
        S_SCORE: begin
          if (int'(in_r.slot) == int'(addr_r)) begin
            hint_rdy_r <= ent_r.st == fsts_pkg::ST_READY;
          end
          if (score_go && !avoid_hit) begin
            state_r <= S_SWAIT;
          end else begin
            if (score_go && fsts_pkg::AVOID_SCORE < best_r) begin
              best_r   <= fsts_pkg::AVOID_SCORE;
              chosen_r <= addr_r;
            end
            state_r <= S_NEXT;
          end
        end
        S_SWAIT: begin
          if (div_done) begin
            if (div_q[31:0] < best_r) begin
              best_r   <= div_q[31:0];
              chosen_r <= addr_r;
            end
            state_r <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (addr_r == LAST_IDX) begin
            state_r <= S_PICK;
          end else begin
            addr_r  <= addr_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_PICK: begin
          chosen_r <= pick_idx;
          addr_r   <= pick_idx;
          state_r  <= S_FRD;
        end
        S_FRD: state_r <= S_FLD;
        S_FLD: begin
          run_r   <= addr_r;
          state_r <= S_DEC;
        end
        S_DEC: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        S_ACK: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_LWAIT || state_r == S_SWAIT))
    else $error("divider finished outside a wait state");

  a_waiter_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == fsts_pkg::RK_MUTEX |-> !out_data.last)
    else $error("timed-out waiter transfer marked last");

  a_run_follows_pick: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FLD |=> run_r == $past(addr_r) && run_r == chosen_r)
    else $error("running slot differs from chosen slot");

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam int NTH = 16;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 3000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  fsts_pkg::fsts_in_t  in_data;
  logic                out_valid;
  logic                out_stall;
  fsts_pkg::fsts_out_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [31:0]         cfg_data;

  fair_share_thread_scheduler #(.NUM_THREADS(NTH)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // thread table mirror
  logic [2:0]  tstate [NTH];
  logic [1:0]  wkind [NTH];
  logic [31:0] wtmo [NTH];
  logic [31:0] wstart [NTH];
  logic [31:0] cpu [NTH];
  logic [7:0]  prio [NTH];
  logic        user [NTH];
  logic [7:0]  load [NTH];
  logic [3:0]  cur_slot;
  logic [31:0] load_stamp;
  logic [31:0] period;
  logic [31:0] tick;
  logic        freeze;

  fsts_pkg::fsts_out_t pending_results[$];
  fsts_pkg::fsts_out_t pin_val;
  logic      pin_on;
  logic      quiet;
  logic      hold_go;
  int        cycles, items, results, mutex_seen, sched_seen, ovf_seen, errors;
  logic [31:0] clock_now;

  typedef struct {
    fsts_pkg::fsts_in_t  it;
    logic                pinned;
    fsts_pkg::fsts_out_t res;
  } row_t;
  row_t rows[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void table_reset();
    for (int i = 0; i < NTH; i++) begin
      tstate[i] = fsts_pkg::ST_ABSENT; wkind[i] = fsts_pkg::KIND_NONE; wtmo[i] = '0;
      wstart[i] = '0; cpu[i] = '0; prio[i] = '0; user[i] = 1'b0; load[i] = '0;
    end
    tstate[0] = fsts_pkg::ST_RUNNING;
    cur_slot = '0;
    load_stamp = '0;
    period = fsts_pkg::LOAD_PERIOD_RST;
    tick = fsts_pkg::RUN_TICK_RST;
    freeze = 1'b0;
  endfunction

  function automatic void forecast(fsts_pkg::fsts_in_t it);
    fsts_pkg::fsts_out_t r, m;
    logic [31:0] left, nxt, best, score, diff;
    logic [63:0] l;
    logic [3:0]  pick;
    int          n;
    r = '0;
    r.result_kind = fsts_pkg::RK_ACK;
    r.thread_slot = it.slot;
    r.last = 1'b1;
    case (it.op)
      fsts_pkg::OP_SCHED: begin
        if (tstate[cur_slot] == fsts_pkg::ST_RUNNING) tstate[cur_slot] = fsts_pkg::ST_READY;
        nxt = fsts_pkg::NO_TIMEOUT;
        pick = '0;
        n = 0;
        r.result_kind = fsts_pkg::RK_SCHED;
        r.wakeup_delay = fsts_pkg::NO_TIMEOUT;
        if (cur_slot != 0 && !it.stack_ok) begin
          for (int i = 0; i < NTH; i++)
            if (user[i] && tstate[i] != fsts_pkg::ST_ABSENT)
              tstate[i] = fsts_pkg::ST_SUSPENDED;
          tstate[cur_slot] = fsts_pkg::ST_DEFUNCT;
          wkind[cur_slot] = fsts_pkg::KIND_NONE;
          r.stack_overflow = 1'b1;
        end
        diff = it.now - load_stamp;
        if (diff > period) begin
          load_stamp = it.now;
          for (int i = 0; i < NTH; i++) begin
            l = (64'd255 * cpu[i]) / diff;
            load[i] = (l > 64'd255) ? fsts_pkg::LOAD_MAX : l[7:0];
            cpu[i] = '0;
          end
        end
        if (!freeze) begin
          for (int i = 0; i < NTH; i++) begin
            if (tstate[i] == fsts_pkg::ST_BLOCKED && wtmo[i] != fsts_pkg::NO_TIMEOUT) begin
              left = wstart[i] + wtmo[i] - it.now;
              if (left[31]) begin
                if (wkind[i] == fsts_pkg::KIND_MUTEX && n < fsts_pkg::MAX_WAITERS) begin
                  m = '0;
                  m.result_kind = fsts_pkg::RK_MUTEX;
                  m.thread_slot = 4'(i);
                  pending_results.push_back(m);
                  n++;
                end
                tstate[i] = fsts_pkg::ST_READY;
                wkind[i] = fsts_pkg::KIND_NONE;
                wtmo[i] = '0;
              end else if (left < nxt) begin
                nxt = left;
              end
            end
          end
          if (it.hint_valid && tstate[it.slot] == fsts_pkg::ST_READY) begin
            pick = it.slot;
          end else begin
            best = fsts_pkg::NO_TIMEOUT;
            for (int i = 0; i < NTH; i++) begin
              if (tstate[i] == fsts_pkg::ST_READY && prio[i] != 0) begin
                if (it.avoid_valid && i == it.avoid_slot) score = fsts_pkg::AVOID_SCORE;
                else score = cpu[i] / prio[i];
                if (score < best) begin
                  best = score;
                  pick = 4'(i);
                end
              end
            end
          end
          if (pick != 0) begin
            r.wakeup_valid = 1'b1;
            r.wakeup_delay = tick;
          end else if (nxt != fsts_pkg::NO_TIMEOUT) begin
            r.wakeup_valid = 1'b1;
            r.wakeup_delay = nxt;
          end
        end
        cur_slot = pick;
        tstate[pick] = fsts_pkg::ST_RUNNING;
        r.thread_slot = pick;
      end
      fsts_pkg::OP_WRITE: begin
        if (it.slot != 0 && it.entry_state != fsts_pkg::EST_BAD) begin
          tstate[it.slot] = (it.entry_state == fsts_pkg::EST_READY) ? fsts_pkg::ST_READY :
                            (it.entry_state == fsts_pkg::EST_SUSP) ? fsts_pkg::ST_SUSPENDED :
                            fsts_pkg::ST_ABSENT;
          user[it.slot] = it.entry_user;
          prio[it.slot] = it.amount[7:0];
          wkind[it.slot] = fsts_pkg::KIND_NONE;
          wtmo[it.slot] = '0;
          wstart[it.slot] = '0;
          cpu[it.slot] = '0;
          load[it.slot] = '0;
        end
      end
      fsts_pkg::OP_BLOCK: begin
        if (cur_slot != 0 && it.timeout != 0 && it.block_kind != fsts_pkg::KIND_BAD) begin
          tstate[cur_slot] = fsts_pkg::ST_BLOCKED;
          wkind[cur_slot] = it.block_kind;
          wtmo[cur_slot] = it.timeout;
          wstart[cur_slot] = it.now;
        end
      end
      fsts_pkg::OP_WAKE: begin
        if (tstate[it.slot] == fsts_pkg::ST_BLOCKED) begin
          tstate[it.slot] = fsts_pkg::ST_READY;
          wkind[it.slot] = fsts_pkg::KIND_NONE;
          wtmo[it.slot] = '0;
        end
      end
      fsts_pkg::OP_CHARGE: cpu[cur_slot] = cpu[cur_slot] + it.amount;
      fsts_pkg::OP_READ: begin
        r.state_out = tstate[it.slot];
        r.load_out = load[it.slot];
      end
      default: ;
    endcase
    pending_results.push_back(r);
  endfunction

  // transfers seen at the rising edge
  always @(posedge clk) begin
    fsts_pkg::fsts_out_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_n && in_valid && !in_stall) begin
      forecast(in_data);
      if (pin_on) begin
        e = pending_results.pop_back();
        pending_results.push_back(pin_val);
      end
      items++;
    end
    if (rst_n && out_valid && !out_stall) begin
      results++;
      if (out_data.result_kind == fsts_pkg::RK_MUTEX) mutex_seen++;
      if (out_data.result_kind == fsts_pkg::RK_SCHED) sched_seen++;
      if (out_data.stack_overflow) ovf_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", out_data);
      end else begin
        e = pending_results.pop_front();
        if (out_data.result_kind !== e.result_kind || out_data.thread_slot !== e.thread_slot ||
            out_data.wakeup_valid !== e.wakeup_valid ||
            out_data.wakeup_delay !== e.wakeup_delay ||
            out_data.stack_overflow !== e.stack_overflow ||
            out_data.state_out !== e.state_out || out_data.load_out !== e.load_out ||
            out_data.last !== e.last) begin
          errors++;
          if (errors <= 10) $display("mismatch at result %0d: exp %p got %p", results, e,
                                     out_data);
        end
      end
    end
  end

  // result side stalls
  initial begin
    out_stall = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall = !quiet && ($urandom_range(99) < 20);
    end
  end

  task automatic send(fsts_pkg::fsts_in_t it, logic pinned, fsts_pkg::fsts_out_t res);
    while (!quiet && $urandom_range(99) < 20) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    pin_on = pinned;
    pin_val = res;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      fsts_pkg::CFG_LOAD_PERIOD: period = val;
      fsts_pkg::CFG_RUN_TICK:    tick = val;
      fsts_pkg::CFG_FROZEN:      freeze = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic fsts_pkg::fsts_in_t mk(logic [2:0] op, logic [3:0] slot, logic hv,
                                            logic [3:0] av, logic avv, logic [31:0] now,
                                            logic sok, logic [31:0] amt, logic [31:0] tmo,
                                            logic [1:0] bk, logic [1:0] est, logic usr);
    fsts_pkg::fsts_in_t it;
    it.op = op; it.slot = slot; it.hint_valid = hv; it.avoid_slot = av;
    it.avoid_valid = avv; it.now = now; it.stack_ok = sok; it.amount = amt;
    it.timeout = tmo; it.block_kind = bk; it.entry_state = est; it.entry_user = usr;
    return it;
  endfunction

  function automatic fsts_pkg::fsts_out_t res(logic [1:0] rk, logic [3:0] sl, logic wv,
                                              logic [31:0] dly, logic [2:0] st);
    fsts_pkg::fsts_out_t r;
    r = '0;
    r.result_kind = rk; r.thread_slot = sl; r.wakeup_valid = wv;
    r.wakeup_delay = dly; r.state_out = st; r.last = 1'b1;
    return r;
  endfunction

  function automatic void add(fsts_pkg::fsts_in_t it, logic pinned = 1'b0,
                              fsts_pkg::fsts_out_t r = '0);
    row_t w;
    w.it = it; w.pinned = pinned; w.res = r;
    rows.push_back(w);
  endfunction

  function automatic fsts_pkg::fsts_in_t rand_item();
    fsts_pkg::fsts_in_t it;
    logic [127:0]       raw;
    int                 pick;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(fsts_pkg::fsts_in_t)-1:0];
    pick = $urandom_range(99);
    it.op = pick < 30 ? fsts_pkg::OP_SCHED : pick < 45 ? fsts_pkg::OP_WRITE :
            pick < 60 ? fsts_pkg::OP_BLOCK : pick < 70 ? fsts_pkg::OP_WAKE :
            pick < 84 ? fsts_pkg::OP_CHARGE : pick < 95 ? fsts_pkg::OP_READ :
            3'($urandom_range(6, 7));
    clock_now = ($urandom_range(19) == 0) ? clock_now + $urandom :
                clock_now + $urandom_range(0, 3000);
    it.now = clock_now;
    it.hint_valid = $urandom_range(99) < 30;
    it.avoid_valid = $urandom_range(99) < 30;
    it.stack_ok = $urandom_range(99) >= 8;
    it.block_kind = 2'($urandom_range(2));
    it.entry_state = 2'($urandom_range(2));
    pick = $urandom_range(9);
    it.timeout = pick == 0 ? -1 : pick == 1 ? 0 : pick == 2 ? $urandom_range(1, 32'h7fffffff)
                 : $urandom_range(1, 5000);
    if (it.op == fsts_pkg::OP_WRITE && $urandom_range(5) != 0)
      it.slot = 4'($urandom_range(1, 7));
    if (it.op == fsts_pkg::OP_CHARGE && $urandom_range(3) != 0)
      it.amount = $urandom_range(0, 20000);
    return it;
  endfunction

  task automatic run_random(int count);
    repeat (count) send(rand_item(), 1'b0, '0);
    settle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = fsts_pkg::CFG_LOAD_PERIOD;
    cfg_data = '0;
    pin_on = 1'b0;
    pin_val = '0;
    quiet = 1'b0;
    hold_go = 1'b0;
    clock_now = 32'd400;
    table_reset();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    add(mk(fsts_pkg::OP_READ, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0), 1'b1,
        res(fsts_pkg::RK_ACK, 0, 0, 0, fsts_pkg::ST_RUNNING));
    add(mk(3'd6, 9, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0), 1'b1,
        res(fsts_pkg::RK_ACK, 9, 0, 0, fsts_pkg::ST_ABSENT));
    add(mk(3'd7, 15, 1, 15, 1, 32'hffffffff, 0, 32'hffffffff, -1, 3, 3, 1), 1'b1,
        res(fsts_pkg::RK_ACK, 15, 0, 0, fsts_pkg::ST_ABSENT));
    add(mk(fsts_pkg::OP_READ, 15, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0), 1'b1,
        res(fsts_pkg::RK_ACK, 15, 0, 0, fsts_pkg::ST_ABSENT));
    add(mk(fsts_pkg::OP_SCHED, 0, 0, 0, 0, 10, 1, 0, 0, 0, 0, 0), 1'b1,
        res(fsts_pkg::RK_SCHED, 0, 0, fsts_pkg::NO_TIMEOUT, fsts_pkg::ST_ABSENT));
    add(mk(fsts_pkg::OP_WRITE, 0, 0, 0, 0, 0, 1, 5, 0, 0, fsts_pkg::EST_READY, 1));
    add(mk(fsts_pkg::OP_WRITE, 1, 0, 0, 0, 0, 1, 255, 0, 0, fsts_pkg::EST_READY, 1));
    add(mk(fsts_pkg::OP_WRITE, 2, 0, 0, 0, 0, 1, 1, 0, 0, fsts_pkg::EST_READY, 0));
    add(mk(fsts_pkg::OP_WRITE, 3, 0, 0, 0, 0, 1, 7, 0, 0, fsts_pkg::EST_BAD, 1));
    add(mk(fsts_pkg::OP_WRITE, 15, 0, 0, 0, 0, 1, 32'h80, 0, 0, fsts_pkg::EST_SUSP, 1));
    add(mk(fsts_pkg::OP_SCHED, 15, 1, 1, 1, 20, 1, 0, 0, 0, 0, 0));
    add(mk(fsts_pkg::OP_CHARGE, 0, 0, 0, 0, 0, 1, 32'hffffffff, 0, 0, 0, 0));
    add(mk(fsts_pkg::OP_BLOCK, 0, 0, 0, 0, 25, 1, 0, -1, 2, 0, 0));
    add(mk(fsts_pkg::OP_SCHED, 0, 0, 0, 0, 30, 1, 0, 0, 0, 0, 0));
    add(mk(fsts_pkg::OP_BLOCK, 0, 0, 0, 0, 31, 1, 0, 0, 1, 0, 0));
    add(mk(fsts_pkg::OP_BLOCK, 0, 0, 0, 0, 32, 1, 0, 5, fsts_pkg::KIND_BAD, 0, 0));
    add(mk(fsts_pkg::OP_BLOCK, 0, 0, 0, 0, 40, 1, 0, 5, fsts_pkg::KIND_MUTEX, 0, 0));
    add(mk(fsts_pkg::OP_WAKE, 4, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    add(mk(fsts_pkg::OP_SCHED, 0, 0, 0, 0, 100, 1, 0, 0, 0, 0, 0));
    add(mk(fsts_pkg::OP_CHARGE, 0, 0, 0, 0, 0, 1, 32'd50000, 0, 0, 0, 0));
    add(mk(fsts_pkg::OP_SCHED, 0, 0, 0, 0, 200000, 0, 0, 0, 0, 0, 0));
    add(mk(fsts_pkg::OP_READ, 1, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    add(mk(fsts_pkg::OP_READ, 2, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    add(mk(fsts_pkg::OP_WRITE, 2, 0, 0, 0, 0, 1, 3, 0, 0, fsts_pkg::EST_READY, 0));
    add(mk(fsts_pkg::OP_SCHED, 2, 1, 0, 0, 200100, 1, 0, 0, 0, 0, 0));
    foreach (rows[k]) send(rows[k].it, rows[k].pinned, rows[k].res);
    pin_on = 1'b0;
    settle();

    quiet = 1'b1;
    cfg_write(fsts_pkg::CFG_LOAD_PERIOD, 32'd1);
    cfg_write(fsts_pkg::CFG_RUN_TICK, fsts_pkg::NO_TIMEOUT);
    run_random(30);
    quiet = 1'b0;

    cfg_write(fsts_pkg::CFG_LOAD_PERIOD, 32'hffffffff);
    cfg_write(fsts_pkg::CFG_RUN_TICK, 32'd1);
    cfg_write(fsts_pkg::CFG_FROZEN, 32'd1);
    run_random(20);

    cfg_write(fsts_pkg::CFG_LOAD_PERIOD, $urandom_range(500, 50000));
    cfg_write(fsts_pkg::CFG_RUN_TICK, $urandom_range(1, 32'hffffffff));
    cfg_write(fsts_pkg::CFG_FROZEN, 32'd0);
    hold_go = 1'b1;
    run_random(35);

    $display("%0d items in, %0d results checked (%0d decisions, %0d mutex timeouts,",
             items, results, sched_seen, mutex_seen);
    $display("  %0d overflow decisions) over four register settings, %0d mismatches",
             ovf_seen, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
